### design/bidm_pkg.sv
// shared types, constants and helpers for the beacon id to channel mapper
`timescale 1ns / 1ps

package bidm_pkg;

  localparam int MAX_SENSORS = 16;
  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNT_W = $clog2(MAX_SENSORS + 1);

  localparam logic [15:0] COMPANY_CODE = 16'h015d;
  localparam logic [7:0]  MIN_PAYLOAD  = 8'd21;

  typedef enum logic [1:0] {
    OP_SIGHTING = 2'd0,
    OP_SCAN     = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_ADD      = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_SHORT       = 4'd0,
    ST_FOREIGN     = 4'd1,
    ST_KNOWN_HIT   = 4'd2,
    ST_NEW_HIT     = 4'd3,
    ST_ADDED       = 4'd4,
    ST_FULL        = 4'd5,
    ST_SCAN        = 4'd6,
    ST_CLEARED     = 4'd7,
    ST_KNOWN_ADDED = 4'd8,
    ST_ADD_FULL    = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [7:0]         payload_length;
    logic [15:0]        company_id;
    logic [63:0]        sensor_id;
    logic signed [7:0]  accel_x;
    logic signed [7:0]  accel_y;
    logic signed [7:0]  accel_z;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  entry_index;
    logic [6:0]  channel_base;
    logic [7:0]  x_positive;
    logic [7:0]  x_negative;
    logic [7:0]  y_positive;
    logic [7:0]  y_negative;
    logic [7:0]  z_positive;
    logic [7:0]  z_negative;
    logic        send_request;
    logic        all_known_seen;
  } out_item_t;

  // twice v for positive v, else 0
  function automatic logic [7:0] pos_part(input logic signed [7:0] v);
    logic [7:0] r;
    r = 8'd0;
    if (!v[7] && (v != 8'sd0)) begin
      r = {v[6:0], 1'b0};
    end
    return r;
  endfunction

  // twice minus v for negative v, -128 wraps to 0
  function automatic logic [7:0] neg_part(input logic signed [7:0] v);
    logic [7:0] r;
    r = 8'd0;
    if (v[7]) begin
      r = 8'd0 - {v[6:0], 1'b0};
    end
    return r;
  endfunction

  // six times the entry index as shift and add
  function automatic logic [6:0] chan_base(input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] p;
    p = {1'b0, idx, 2'b00} + {2'b00, idx, 1'b0};
    return 7'(p);
  endfunction

  // one bit per table position below cnt
  function automatic logic [MAX_SENSORS-1:0] below_mask(input logic [CNT_W-1:0] cnt);
    logic [MAX_SENSORS-1:0] m;
    for (int i = 0; i < MAX_SENSORS; i++) begin
      m[i] = (CNT_W'(i) < cnt);
    end
    return m;
  endfunction

endpackage

### design/beacon_id_table_to_channel_mapper_unit.sv
// beacon id table to channel mapper: table search sequencer and result register
`timescale 1ns / 1ps

// Takes one item at a time (sighting or table command) and returns exactly one result
// for it. A sighting of the right company with a payload of at least 21 bytes is
// compared against the id table one entry per cycle through a single 64-bit comparator
// fed by the registered read port of the table memory, so a sighting's time from one
// input transfer to the next grows with the position of the hit, or with the number of
// entries on a miss; commands, dropped sightings and a sighting into an empty table skip
// the search. The single table read port and comparator set the search pace, and a
// stalled result register holds back the next item too. A finished result sits in the
// output register while the next item is taken; the user must write output_enabled
// through cfg_we/cfg_wdata only while idle, and the block itself does not enforce it.
module beacon_id_table_to_channel_mapper_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bidm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bidm_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);

  localparam int MAX = bidm_pkg::MAX_SENSORS;
  localparam int IW  = bidm_pkg::IDX_W;
  localparam int CW  = bidm_pkg::CNT_W;

  bidm_pkg::fsm_state_t state_r, state_nxt;

  bidm_pkg::in_item_t   item_r;
  bidm_pkg::out_item_t  out_r, out_nxt;
  logic                 out_valid_r;
  logic                 out_en_r;

  logic [CW-1:0]        known_r, known_nxt;
  logic [CW-1:0]        new_r, new_nxt;
  logic [MAX-1:0]       seen_r, seen_nxt;

  logic [CW-1:0]        ptr_r;
  logic                 cmp_vld_r;
  logic [IW-1:0]        cmp_idx_r;
  logic [63:0]          rdata_r;
  logic [63:0]          id_mem [MAX];

  bidm_pkg::status_t    res_status_r;
  logic [IW-1:0]        res_idx_r;

  logic [CW-1:0]        total;
  logic                 accept;
  logic                 fin_go;
  logic                 mem_we;
  logic                 srch_hit;
  logic                 srch_miss;

  bidm_pkg::status_t    cls_status;
  logic [IW-1:0]        cls_idx;
  logic                 cls_search;

  assign total     = CW'({1'b0, known_r} + {1'b0, new_r});
  assign accept    = in_valid && in_ready;
  assign srch_hit  = cmp_vld_r && (rdata_r == item_r.sensor_id);
  assign srch_miss = !cmp_vld_r && (ptr_r == total);

  // first look at a new item
  always_comb begin
    cls_status = bidm_pkg::ST_SHORT;
    cls_idx    = '0;
    cls_search = 1'b0;
    unique case (in_data.opcode)
      bidm_pkg::OP_SIGHTING: begin
        if (in_data.payload_length < bidm_pkg::MIN_PAYLOAD) begin
          cls_status = bidm_pkg::ST_SHORT;
        end else if (in_data.company_id != bidm_pkg::COMPANY_CODE) begin
          cls_status = bidm_pkg::ST_FOREIGN;
        end else if (total == '0) begin
          // empty table, straight to append at position 0
          cls_status = bidm_pkg::ST_ADDED;
        end else begin
          cls_search = 1'b1;
        end
      end
      bidm_pkg::OP_SCAN: begin
        cls_status = bidm_pkg::ST_SCAN;
      end
      bidm_pkg::OP_CLEAR: begin
        cls_status = bidm_pkg::ST_CLEARED;
      end
      bidm_pkg::OP_ADD: begin
        if (known_r < CW'(MAX)) begin
          cls_status = bidm_pkg::ST_KNOWN_ADDED;
          cls_idx    = known_r[IW-1:0];
        end else begin
          cls_status = bidm_pkg::ST_ADD_FULL;
        end
      end
      default: begin
        cls_status = bidm_pkg::ST_SHORT;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bidm_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = cls_search ? bidm_pkg::S_SEARCH : bidm_pkg::S_FINISH;
        end
      end
      bidm_pkg::S_SEARCH: begin
        if (srch_hit || srch_miss) begin
          state_nxt = bidm_pkg::S_FINISH;
        end
      end
      bidm_pkg::S_FINISH: begin
        if (fin_go) begin
          state_nxt = bidm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bidm_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    fin_go   = 1'b0;
    mem_we   = 1'b0;
    unique case (state_r)
      bidm_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      bidm_pkg::S_SEARCH: begin
        in_ready = 1'b0;
      end
      bidm_pkg::S_FINISH: begin
        fin_go = !out_valid_r || out_ready;
        mem_we = fin_go && ((res_status_r == bidm_pkg::ST_ADDED) ||
                            (res_status_r == bidm_pkg::ST_KNOWN_ADDED));
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // table state after the finishing item
  always_comb begin
    known_nxt = known_r;
    new_nxt   = new_r;
    seen_nxt  = seen_r;
    if (fin_go) begin
      unique case (res_status_r)
        bidm_pkg::ST_KNOWN_HIT,
        bidm_pkg::ST_NEW_HIT: begin
          seen_nxt[res_idx_r] = 1'b1;
        end
        bidm_pkg::ST_ADDED: begin
          seen_nxt[res_idx_r] = 1'b1;
          new_nxt             = new_r + 1'b1;
        end
        bidm_pkg::ST_SCAN: begin
          seen_nxt = seen_r & ~bidm_pkg::below_mask(known_r);
        end
        bidm_pkg::ST_CLEARED: begin
          known_nxt = '0;
          new_nxt   = '0;
          seen_nxt  = '0;
        end
        bidm_pkg::ST_KNOWN_ADDED: begin
          seen_nxt[res_idx_r] = 1'b0;
          known_nxt           = known_r + 1'b1;
          new_nxt             = '0;
        end
        default: begin
          known_nxt = known_r;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    logic has_index;
    logic hit;
    has_index = (res_status_r == bidm_pkg::ST_KNOWN_HIT) ||
                (res_status_r == bidm_pkg::ST_NEW_HIT) ||
                (res_status_r == bidm_pkg::ST_ADDED) ||
                (res_status_r == bidm_pkg::ST_KNOWN_ADDED);
    hit       = (res_status_r == bidm_pkg::ST_KNOWN_HIT) ||
                (res_status_r == bidm_pkg::ST_NEW_HIT);
    out_nxt                = '0;
    out_nxt.status         = res_status_r;
    out_nxt.entry_index    = has_index ? 4'(res_idx_r) : 4'd0;
    out_nxt.channel_base   = has_index ? bidm_pkg::chan_base(res_idx_r) : 7'd0;
    if (hit) begin
      out_nxt.x_positive = bidm_pkg::pos_part(item_r.accel_x);
      out_nxt.x_negative = bidm_pkg::neg_part(item_r.accel_x);
      out_nxt.y_positive = bidm_pkg::pos_part(item_r.accel_y);
      out_nxt.y_negative = bidm_pkg::neg_part(item_r.accel_y);
      out_nxt.z_positive = bidm_pkg::pos_part(item_r.accel_z);
      out_nxt.z_negative = bidm_pkg::neg_part(item_r.accel_z);
    end
    out_nxt.send_request   = (res_status_r == bidm_pkg::ST_KNOWN_HIT) && out_en_r;
    out_nxt.all_known_seen = &(seen_nxt | ~bidm_pkg::below_mask(known_nxt));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bidm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      out_en_r    <= 1'b0;
      known_r     <= '0;
      new_r       <= '0;
      seen_r      <= '0;
      cmp_vld_r   <= 1'b0;
      ptr_r       <= '0;
    end else begin
      state_r <= state_nxt;
      known_r <= known_nxt;
      new_r   <= new_nxt;
      seen_r  <= seen_nxt;
      if (cfg_we) begin
        out_en_r <= cfg_wdata;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        ptr_r     <= '0;
        cmp_vld_r <= 1'b0;
      end else if (state_r == bidm_pkg::S_SEARCH) begin
        // read runs one entry ahead of the compare
        cmp_vld_r <= (ptr_r < total) && !srch_hit;
        if (ptr_r != total) begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r       <= in_data;
      res_status_r <= cls_status;
      res_idx_r    <= cls_idx;
    end else if (state_r == bidm_pkg::S_SEARCH) begin
      cmp_idx_r <= ptr_r[IW-1:0];
      if (srch_hit) begin
        res_status_r <= (CW'(cmp_idx_r) < known_r) ? bidm_pkg::ST_KNOWN_HIT
                                                    : bidm_pkg::ST_NEW_HIT;
        res_idx_r    <= cmp_idx_r;
      end else if (srch_miss) begin
        if (total < CW'(MAX)) begin
          res_status_r <= bidm_pkg::ST_ADDED;
          res_idx_r    <= total[IW-1:0];
        end else begin
          res_status_r <= bidm_pkg::ST_FULL;
          res_idx_r    <= '0;
        end
      end
    end
    if (fin_go) begin
      out_r <= out_nxt;
    end
  end

  // id table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[res_idx_r] <= item_r.sensor_id;
    end
    rdata_r <= id_mem[ptr_r[IW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### design/bidm_checker.sv
// port level checks for the beacon id to channel mapper, bound to the top level
`timescale 1ns / 1ps

module bidm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input bidm_pkg::out_item_t  out_data
);

  // a held result stays until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // one item at a time: no second transfer right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in work");

  // send request only on a known hit
  a_send_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.send_request |-> out_data.status == bidm_pkg::ST_KNOWN_HIT)
    else $error("send request without known hit");

  // channel values only on hits
  a_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != bidm_pkg::ST_KNOWN_HIT &&
    out_data.status != bidm_pkg::ST_NEW_HIT |->
    out_data.x_positive == 8'd0 && out_data.x_negative == 8'd0 &&
    out_data.y_positive == 8'd0 && out_data.y_negative == 8'd0 &&
    out_data.z_positive == 8'd0 && out_data.z_negative == 8'd0)
    else $error("channel values on a non-hit result");

  // channel base follows the entry index
  a_base_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.channel_base == bidm_pkg::chan_base(out_data.entry_index))
    else $error("channel base does not match entry index");

endmodule

bind beacon_id_table_to_channel_mapper_unit bidm_checker u_bidm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### bench/bidm_result_checker.sv
// result checker for the beacon id table to channel mapper: predicts and compares results
`timescale 1ns / 1ps

module bidm_result_checker
  import bidm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output int        fail_count,
  output int        pending_results
);

  // shadow copy of the table and the register
  logic [63:0]            sensor_ids [MAX_SENSORS];
  logic [MAX_SENSORS-1:0] seen_bits;
  int                     known_n;
  int                     fresh_n;
  logic                   send_enable;

  out_item_t expected_results [$];
  int        mismatch_n = 0;
  int        taken_n = 0;
  int        returned_n = 0;

  assign fail_count      = mismatch_n;
  assign pending_results = taken_n - returned_n;

  function automatic logic [7:0] twice_up(input logic signed [7:0] v);
    return (v > 0) ? 8'(2 * int'(v)) : 8'd0;
  endfunction

  function automatic logic [7:0] twice_down(input logic signed [7:0] v);
    return (v < 0) ? 8'(-2 * int'(v)) : 8'd0;
  endfunction

  function automatic string show(input out_item_t r);
    return $sformatf("st=%0d idx=%0d base=%0d x=%0d/%0d y=%0d/%0d z=%0d/%0d send=%0b all=%0b",
                     r.status, r.entry_index, r.channel_base, r.x_positive, r.x_negative,
                     r.y_positive, r.y_negative, r.z_positive, r.z_negative,
                     r.send_request, r.all_known_seen);
  endfunction

  // one item through the table, one result out
  task automatic map_item(input in_item_t it, output out_item_t r);
    int total;
    int pos;
    r = '0;
    total = known_n + fresh_n;
    pos = -1;
    case (it.opcode)
      OP_SIGHTING: begin
        if (it.payload_length < MIN_PAYLOAD) begin
          r.status = ST_SHORT;
        end else if (it.company_id != COMPANY_CODE) begin
          r.status = ST_FOREIGN;
        end else begin
          // lowest matching position wins
          for (int i = 0; i < total; i++) begin
            if (pos < 0 && sensor_ids[i] == it.sensor_id) pos = i;
          end
          if (pos >= 0) begin
            seen_bits[pos] = 1'b1;
            r.entry_index  = 4'(pos);
            r.channel_base = 7'(pos * 6);
            r.x_positive   = twice_up(it.accel_x);
            r.x_negative   = twice_down(it.accel_x);
            r.y_positive   = twice_up(it.accel_y);
            r.y_negative   = twice_down(it.accel_y);
            r.z_positive   = twice_up(it.accel_z);
            r.z_negative   = twice_down(it.accel_z);
            if (pos < known_n) begin
              r.status       = ST_KNOWN_HIT;
              r.send_request = send_enable;
            end else begin
              r.status = ST_NEW_HIT;
            end
          end else if (total < MAX_SENSORS) begin
            sensor_ids[total] = it.sensor_id;
            seen_bits[total]  = 1'b1;
            fresh_n++;
            r.status       = ST_ADDED;
            r.entry_index  = 4'(total);
            r.channel_base = 7'(total * 6);
          end else begin
            r.status = ST_FULL;
          end
        end
      end
      OP_SCAN: begin
        for (int i = 0; i < known_n; i++) seen_bits[i] = 1'b0;
        r.status = ST_SCAN;
      end
      OP_CLEAR: begin
        known_n   = 0;
        fresh_n   = 0;
        seen_bits = '0;
        r.status  = ST_CLEARED;
      end
      default: begin
        if (known_n < MAX_SENSORS) begin
          sensor_ids[known_n] = it.sensor_id;
          seen_bits[known_n]  = 1'b0;
          r.status       = ST_KNOWN_ADDED;
          r.entry_index  = 4'(known_n);
          r.channel_base = 7'(known_n * 6);
          known_n++;
          fresh_n = 0;
        end else begin
          r.status = ST_ADD_FULL;
        end
      end
    endcase
    r.all_known_seen = 1'b1;
    for (int i = 0; i < known_n; i++) begin
      if (!seen_bits[i]) r.all_known_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t next_result;
    if (!rst_n) begin
      for (int i = 0; i < MAX_SENSORS; i++) sensor_ids[i] = '0;
      seen_bits   = '0;
      known_n     = 0;
      fresh_n     = 0;
      send_enable = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) send_enable = cfg_wdata;
      if (out_valid && out_ready) begin
        returned_n <= returned_n + 1;
        if (expected_results.size() == 0) begin
          mismatch_n++;
          $display("%0t: result with nothing outstanding: %s", $time, show(out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            mismatch_n++;
            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                     $time, show(want), show(out_data));
          end
        end
      end
      if (in_valid && in_ready) begin
        taken_n <= taken_n + 1;
        map_item(in_data, next_result);
        expected_results.push_back(next_result);
      end
    end
  end

endmodule

### bench/testbench.sv
// top of the bench: clock, reset, stimulus, receiver pacing, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
  import bidm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 30;
  localparam int POOL_N         = 24;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  int  fail_count;
  int  pending_results;
  int  quiet_cycles = 0;
  int  rest_cycles = 0;
  bit  offering = 1'b0;
  bit  idle_on = 1'b1;
  bit  hold_off_req = 1'b0;

  logic [63:0] id_pool [POOL_N];

  beacon_id_table_to_channel_mapper_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bidm_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // offer one item; valid stays up into the next item when no gap is drawn
  task automatic offer(input in_item_t it);
    if (rest_cycles > 0) repeat (rest_cycles) @(posedge clk);
    in_data  <= it;
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    rest_cycles = idle_on ? $urandom_range(0, 8) : 0;
    if (rest_cycles > 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // stop offering and wait until every result has come back
  task automatic settle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    rest_cycles = 0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic in_item_t sighting(input logic [7:0] len, input logic [15:0] company,
                                        input logic [63:0] id, input logic [7:0] ax,
                                        input logic [7:0] ay, input logic [7:0] az);
    in_item_t it;
    it.opcode         = OP_SIGHTING;
    it.payload_length = len;
    it.company_id     = company;
    it.sensor_id      = id;
    it.accel_x        = ax;
    it.accel_y        = ay;
    it.accel_z        = az;
    return it;
  endfunction

  function automatic in_item_t command(input opcode_t op, input logic [63:0] id);
    in_item_t it;
    it = sighting(8'($urandom), 16'($urandom), id, 8'($urandom), 8'($urandom), 8'($urandom));
    it.opcode = op;
    return it;
  endfunction

  // mostly well-formed sightings from a small id pool so the table hits and fills
  function automatic in_item_t random_item(input int add_pct, input int clear_pct);
    in_item_t it;
    int       pick;
    logic [63:0] id;
    pick = $urandom_range(0, 99);
    id = ($urandom_range(0, 4) != 0) ? id_pool[$urandom_range(0, POOL_N - 1)]
                                     : {$urandom, $urandom};
    it = sighting(8'($urandom_range(21, 255)), COMPANY_CODE, id,
                  8'($urandom), 8'($urandom), 8'($urandom));
    if (pick < add_pct) begin
      it.opcode = OP_ADD;
    end else if (pick < add_pct + 6) begin
      it = command(OP_SCAN, id);
    end else if (pick < add_pct + 6 + clear_pct) begin
      it = command(OP_CLEAR, id);
    end else if (pick < add_pct + 13 + clear_pct) begin
      it.payload_length = 8'($urandom_range(0, 20));
      if ($urandom_range(0, 1) != 0) it.company_id = 16'($urandom);
    end else if (pick < add_pct + 20 + clear_pct) begin
      it.company_id = 16'($urandom);
      if (it.company_id == COMPANY_CODE) it.company_id[0] = ~it.company_id[0];
    end
    return it;
  endfunction

  // receiver pacing, with one long hold-off on request
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      w = idle_on ? $urandom_range(0, 8) : 0;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("** beacon_id_table_to_channel_mapper_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL_N; i++) id_pool[i] = {$urandom, $urandom};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_enable(1'b0);

    // directed: drop reasons, new entry and hit, fill known part, overflow cases
    offer(sighting(8'd20, COMPANY_CODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h80, 8'h7F, 8'hFF));
    offer(sighting(8'd21, 16'h015c, 64'h0, 8'h01, 8'h00, 8'h80));
    offer(sighting(8'd21, COMPANY_CODE, 64'h0, 8'h10, 8'hF0, 8'h00));
    offer(sighting(8'd255, COMPANY_CODE, 64'h0, 8'h7F, 8'h80, 8'h00));
    for (int i = 0; i < MAX_SENSORS; i++) offer(command(OP_ADD, id_pool[i]));
    offer(command(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF));
    offer(sighting(8'd100, COMPANY_CODE, id_pool[MAX_SENSORS - 1], 8'hFF, 8'h01, 8'h81));
    offer(sighting(8'd200, COMPANY_CODE, {$urandom, $urandom}, 8'h05, 8'hFB, 8'h40));
    offer(command(OP_SCAN, 64'h0));
    offer(command(OP_CLEAR, 64'h0));
    settle();

    // send requests on, receiver holds off while the sender keeps offering
    write_enable(1'b1);
    hold_off_req = 1'b1;
    repeat (250) offer(random_item(8, 3));
    settle();

    // send requests off, no idling on either side
    write_enable(1'b0);
    idle_on = 1'b0;
    repeat (200) offer(random_item(8, 3));
    settle();

    // add-heavy mix so the known part fills up
    idle_on = 1'b1;
    write_enable(1'b1);
    repeat (250) offer(random_item(20, 1));
    settle();

    if (fail_count == 0 && pending_results == 0) begin
      $display("** beacon_id_table_to_channel_mapper_unit: PASSED **");
    end else begin
      $display("** beacon_id_table_to_channel_mapper_unit: FAILED **");
    end
    $finish;
  end

endmodule
